### rtl/core/sleb_pkg.sv
// Shared widths, control codes and types for the simplex Lagrange basis evaluator.
`default_nettype none

package sleb_pkg;

  // Item layout.
  localparam int LAT_N = 4;
  localparam int LAT_W = 4;
  localparam int CRD_N = 3;
  localparam int CRD_W = 32;
  localparam int IN_W  = 112;
  localparam int OUT_W = 48;
  localparam int DIM_W = 2;
  localparam logic [DIM_W-1:0] DIM_RESET = 2'd2;

  // Fixed-point format and order limit.
  localparam int FRAC      = 28;
  localparam int MAX_ORDER = 8;
  localparam int D_W       = $clog2(MAX_ORDER + 1);
  localparam int SUM_W     = 6;
  localparam longint ONE_Q = 64'd1 << FRAC;

  // Datapath widths.
  localparam int W_W   = 34;
  localparam int T_W   = D_W + W_W + 1;
  localparam int TM_W  = T_W - 1;
  localparam int MAG_W = 47;
  localparam int ML_W  = 24;
  localparam int PP_W  = ML_W + TM_W;
  localparam int ACC_W = MAG_W + TM_W + 1;

  // Quotient unit: one 8-bit digit per cycle.
  localparam int DIGIT_W   = 8;
  localparam int DIV_W     = 64;
  localparam int DIV_STEPS = DIV_W / DIGIT_W;
  localparam int DEN_W     = LAT_W;

  // Saturated results.
  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  // Datapath operations.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
  localparam logic [OP_W-1:0] OP_SEL   = 4'd2;
  localparam logic [OP_W-1:0] OP_TERM  = 4'd3;
  localparam logic [OP_W-1:0] OP_SIGN  = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL0  = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL1  = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL2  = 4'd7;
  localparam logic [OP_W-1:0] OP_DIVGO = 4'd8;
  localparam logic [OP_W-1:0] OP_UPD   = 4'd9;
  localparam logic [OP_W-1:0] OP_PINC  = 4'd10;
  localparam logic [OP_W-1:0] OP_QINC  = 4'd11;
  localparam logic [OP_W-1:0] OP_OUT   = 4'd12;

  // Hold conditions: the step repeats while its condition is true.
  localparam int HOLD_W = 2;
  localparam logic [HOLD_W-1:0] HOLD_NONE  = 2'd0;
  localparam logic [HOLD_W-1:0] HOLD_INPUT = 2'd1;
  localparam logic [HOLD_W-1:0] HOLD_DIV   = 2'd2;
  localparam logic [HOLD_W-1:0] HOLD_OUT   = 2'd3;

  // Jump conditions.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_NONE       = 3'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS     = 3'd1;
  localparam logic [COND_W-1:0] COND_ORDER_HIGH = 3'd2;
  localparam logic [COND_W-1:0] COND_P_DONE     = 3'd3;
  localparam logic [COND_W-1:0] COND_T_ZERO     = 3'd4;
  localparam logic [COND_W-1:0] COND_SAT        = 3'd5;
  localparam logic [COND_W-1:0] COND_LAST_COORD = 3'd6;

  // Microcode address width.
  localparam int UA_W = 5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [HOLD_W-1:0] hold;
    logic [COND_W-1:0] cond;
    logic [UA_W-1:0]   target;
  } ucw_t;

  typedef struct packed {
    logic order_high;
    logic p_done;
    logic t_zero;
    logic sat;
    logic last_coord;
    logic div_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/sleb_div.sv
// Iterative quotient unit: wide numerator over a small divisor, one digit per cycle.
`default_nettype none

module sleb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sleb_pkg::DIV_W-1:0] num,
  input  logic [sleb_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [sleb_pkg::DIV_W-1:0] quot
);
  import sleb_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [DIV_W-1:0]   work;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   dv;
  logic [CNT_W-1:0]   cnt;
  logic [DIGIT_W-1:0] digit;
  logic [DIGIT_W-1:0] qd;
  logic [DEN_W-1:0]   rem_next;
  logic [DEN_W:0]     trial;

  assign digit = work[DIV_W-1 -: DIGIT_W];
  assign quot  = work;

  // Restoring division over the bits of the top digit.
  always_comb begin
    rem_next = rem;
    qd       = '0;
    trial    = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      trial = {rem_next, digit[i]};
      if (trial >= {1'b0, dv}) begin
        rem_next = DEN_W'(trial - {1'b0, dv});
        qd[i]    = 1'b1;
      end else begin
        rem_next = trial[DEN_W-1:0];
      end
    end
  end

  // Control: busy until every digit has been produced.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Numerator shifts out at the top while quotient digits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      rem  <= '0;
      dv   <= den;
    end else if (busy) begin
      work <= {work[DIV_W-DIGIT_W-1:0], qd};
      rem  <= rem_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sleb_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module sleb_seq (
  input  logic               clk,
  input  logic               rst,
  input  sleb_pkg::dp_stat_t stat,
  input  logic               in_valid,
  input  logic               out_busy,
  output sleb_pkg::ucw_t     cw,
  output logic               advance
);
  import sleb_pkg::*;

  // Step addresses.
  localparam logic [UA_W-1:0] S_IDLE   = 5'd0;
  localparam logic [UA_W-1:0] S_CHKORD = 5'd1;
  localparam logic [UA_W-1:0] S_COORD  = 5'd2;
  localparam logic [UA_W-1:0] S_PLOOP  = 5'd3;
  localparam logic [UA_W-1:0] S_TERM   = 5'd4;
  localparam logic [UA_W-1:0] S_SIGN   = 5'd5;
  localparam logic [UA_W-1:0] S_SATCHK = 5'd6;
  localparam logic [UA_W-1:0] S_MUL0   = 5'd7;
  localparam logic [UA_W-1:0] S_MUL1   = 5'd8;
  localparam logic [UA_W-1:0] S_MUL2   = 5'd9;
  localparam logic [UA_W-1:0] S_DIVGO  = 5'd10;
  localparam logic [UA_W-1:0] S_DIVW   = 5'd11;
  localparam logic [UA_W-1:0] S_UPD    = 5'd12;
  localparam logic [UA_W-1:0] S_PNEXT  = 5'd13;
  localparam logic [UA_W-1:0] S_NEXTC  = 5'd14;
  localparam logic [UA_W-1:0] S_QINC   = 5'd15;
  localparam logic [UA_W-1:0] S_OUT    = 5'd16;

  logic [UA_W-1:0] upc;
  logic [UA_W-1:0] upc_next;
  logic            stall;
  logic            taken;

  function automatic ucw_t uw(input logic [OP_W-1:0] op, input logic [HOLD_W-1:0] hold,
                              input logic [COND_W-1:0] cond, input logic [UA_W-1:0] target);
    ucw_t c;
    c.op     = op;
    c.hold   = hold;
    c.cond   = cond;
    c.target = target;
    return c;
  endfunction

  // Control store: one word per step.
  always_comb begin
    case (upc)
      S_IDLE:   cw = uw(OP_LOAD,  HOLD_INPUT, COND_NONE,       S_IDLE);
      S_CHKORD: cw = uw(OP_NOP,   HOLD_NONE,  COND_ORDER_HIGH, S_OUT);
      S_COORD:  cw = uw(OP_SEL,   HOLD_NONE,  COND_NONE,       S_IDLE);
      S_PLOOP:  cw = uw(OP_NOP,   HOLD_NONE,  COND_P_DONE,     S_NEXTC);
      S_TERM:   cw = uw(OP_TERM,  HOLD_NONE,  COND_NONE,       S_IDLE);
      S_SIGN:   cw = uw(OP_SIGN,  HOLD_NONE,  COND_T_ZERO,     S_OUT);
      S_SATCHK: cw = uw(OP_NOP,   HOLD_NONE,  COND_SAT,        S_PNEXT);
      S_MUL0:   cw = uw(OP_MUL0,  HOLD_NONE,  COND_NONE,       S_IDLE);
      S_MUL1:   cw = uw(OP_MUL1,  HOLD_NONE,  COND_NONE,       S_IDLE);
      S_MUL2:   cw = uw(OP_MUL2,  HOLD_NONE,  COND_NONE,       S_IDLE);
      S_DIVGO:  cw = uw(OP_DIVGO, HOLD_NONE,  COND_NONE,       S_IDLE);
      S_DIVW:   cw = uw(OP_NOP,   HOLD_DIV,   COND_NONE,       S_IDLE);
      S_UPD:    cw = uw(OP_UPD,   HOLD_NONE,  COND_NONE,       S_IDLE);
      S_PNEXT:  cw = uw(OP_PINC,  HOLD_NONE,  COND_ALWAYS,     S_PLOOP);
      S_NEXTC:  cw = uw(OP_NOP,   HOLD_NONE,  COND_LAST_COORD, S_OUT);
      S_QINC:   cw = uw(OP_QINC,  HOLD_NONE,  COND_ALWAYS,     S_COORD);
      S_OUT:    cw = uw(OP_OUT,   HOLD_OUT,   COND_ALWAYS,     S_IDLE);
      default:  cw = uw(OP_NOP,   HOLD_NONE,  COND_ALWAYS,     S_IDLE);
    endcase
  end

  // A step repeats while its hold condition is true.
  always_comb begin
    case (cw.hold)
      HOLD_INPUT: stall = !in_valid;
      HOLD_DIV:   stall = stat.div_busy;
      HOLD_OUT:   stall = out_busy;
      default:    stall = 1'b0;
    endcase
  end

  // Jump condition select.
  always_comb begin
    case (cw.cond)
      COND_ALWAYS:     taken = 1'b1;
      COND_ORDER_HIGH: taken = stat.order_high;
      COND_P_DONE:     taken = stat.p_done;
      COND_T_ZERO:     taken = stat.t_zero;
      COND_SAT:        taken = stat.sat;
      COND_LAST_COORD: taken = stat.last_coord;
      default:         taken = 1'b0;
    endcase
  end

  assign advance  = !stall;
  assign upc_next = stall ? upc : (taken ? cw.target : UA_W'(upc + 1'b1));

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sleb_dp.sv
// Datapath: item registers, factor formation, shared multiplier and result selection.
`default_nettype none

module sleb_dp (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic [sleb_pkg::OP_W-1:0]                      op,
  input  logic                                           exec,
  input  logic [sleb_pkg::DIM_W-1:0]                     dim,
  input  logic [sleb_pkg::LAT_N-1:0][sleb_pkg::LAT_W-1:0] lat_in,
  input  logic [sleb_pkg::CRD_N-1:0][sleb_pkg::CRD_W-1:0] crd_in,
  output sleb_pkg::dp_stat_t                             stat,
  output logic [sleb_pkg::OUT_W-1:0]                     res_value,
  output logic                                           res_ovf
);
  import sleb_pkg::*;

  // Item and working registers.
  logic [LAT_N-1:0][LAT_W-1:0] lat;
  logic [CRD_N-1:0][CRD_W-1:0] crd;
  logic [SUM_W-1:0]            d;
  logic [DIM_W-1:0]            qi;
  logic [LAT_W-1:0]            pc;
  logic signed [W_W-1:0]       w;
  logic signed [T_W-1:0]       t;
  logic [DEN_W-1:0]            k;
  logic [MAG_W-1:0]            mag;
  logic                        neg;
  logic                        sat;
  logic                        zero;
  logic [PP_W-1:0]             pp;
  logic [ACC_W-1:0]            acc;

  logic [SUM_W-1:0]      d_load;
  logic [LAT_W-1:0]      entry;
  logic [CRD_W-1:0]      crd_pick;
  logic signed [W_W-1:0] crd_ext;
  logic signed [W_W-1:0] x_sel;
  logic signed [D_W:0]   d_s;
  logic signed [T_W-1:0] dx;
  logic signed [T_W-1:0] pc_off;
  logic signed [T_W-1:0] t_calc;
  logic [T_W-1:0]        t_abs;
  logic [TM_W-1:0]       tm;
  logic [ML_W-1:0]       mul_op;
  logic [PP_W-1:0]       pp_calc;
  logic                  div_start;
  logic                  div_busy;
  logic [DIV_W-1:0]      quot;
  logic                  order_high;

  // Order is the sum of the lattice entries in use.
  always_comb begin
    d_load = SUM_W'(lat_in[0]);
    if (dim >= DIM_W'(1)) d_load = d_load + SUM_W'(lat_in[1]);
    if (dim >= DIM_W'(2)) d_load = d_load + SUM_W'(lat_in[2]);
    if (dim >= DIM_W'(3)) d_load = d_load + SUM_W'(lat_in[3]);
  end

  // Current coordinate; the last pass uses the barycentric remainder w.
  always_comb begin
    case (qi)
      2'd0:    crd_pick = crd[0];
      2'd1:    crd_pick = crd[1];
      2'd2:    crd_pick = crd[2];
      default: crd_pick = '0;
    endcase
  end

  assign crd_ext = $signed({{(W_W-CRD_W){crd_pick[CRD_W-1]}}, crd_pick});
  assign x_sel   = (qi < dim) ? crd_ext : w;
  assign entry   = lat[qi];

  // Factor term t = d*x - p, exact in the fractional format.
  assign d_s    = $signed({1'b0, d[D_W-1:0]});
  assign dx     = T_W'(d_s) * T_W'(x_sel);
  assign pc_off = $signed({{(T_W-LAT_W-FRAC){1'b0}}, pc, {FRAC{1'b0}}});
  assign t_calc = dx - pc_off;

  assign t_abs = t[T_W-1] ? $unsigned(-t) : $unsigned(t);
  assign tm    = t_abs[TM_W-1:0];

  // One multiplier serves both halves of the running magnitude.
  assign mul_op  = (op == OP_MUL0) ? mag[ML_W-1:0] : ML_W'(mag[MAG_W-1:ML_W]);
  assign pp_calc = PP_W'(mul_op) * PP_W'(tm);

  // Rounded product is divided by the falling factorial term k.
  assign div_start = exec && (op == OP_DIVGO);

  sleb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (DIV_W'(acc[ACC_W-1:FRAC])),
    .den   (k),
    .busy  (div_busy),
    .quot  (quot)
  );

  // Register updates per microcode operation.
  always_ff @(posedge clk) begin
    if (exec) begin
      case (op)
        OP_LOAD: begin
          lat  <= lat_in;
          crd  <= crd_in;
          d    <= d_load;
          mag  <= MAG_W'(ONE_Q);
          neg  <= 1'b0;
          sat  <= 1'b0;
          zero <= 1'b0;
          qi   <= '0;
          w    <= W_W'(ONE_Q);
        end
        OP_SEL: begin
          pc <= '0;
          if (qi < dim) begin
            w <= w - crd_ext;
          end
        end
        OP_TERM: begin
          t <= t_calc;
          k <= entry - pc;
        end
        OP_SIGN: begin
          if (t == '0) begin
            zero <= 1'b1;
          end else if (t[T_W-1]) begin
            neg <= ~neg;
          end
        end
        OP_MUL0: pp <= pp_calc;
        OP_MUL1: begin
          acc <= ACC_W'(pp) + ACC_W'({k, {(FRAC-1){1'b0}}});
          pp  <= pp_calc;
        end
        OP_MUL2: acc <= acc + (ACC_W'(pp) << ML_W);
        OP_UPD: begin
          if (|quot[DIV_W-1:MAG_W]) begin
            sat <= 1'b1;
          end else begin
            mag <= quot[MAG_W-1:0];
          end
        end
        OP_PINC: pc <= pc + 1'b1;
        OP_QINC: qi <= qi + 1'b1;
        default: ;
      endcase
    end
  end

  // Status toward the sequencer.
  assign order_high      = d > SUM_W'(MAX_ORDER);
  assign stat.order_high = order_high;
  assign stat.p_done     = pc >= entry;
  assign stat.t_zero     = t == '0;
  assign stat.sat        = sat;
  assign stat.last_coord = qi == dim;
  assign stat.div_busy   = div_busy;

  // Final value with its special cases.
  always_comb begin
    res_value = '0;
    res_ovf   = 1'b0;
    if (order_high) begin
      res_ovf = 1'b1;
    end else if (zero) begin
      res_ovf = 1'b0;
    end else if (sat) begin
      res_ovf   = 1'b1;
      res_value = neg ? SAT_NEG : SAT_POS;
    end else begin
      res_value = neg ? (OUT_W'(0) - OUT_W'(mag)) : OUT_W'(mag);
    end
  end

endmodule

`default_nettype wire

### rtl/core/simplex_lagrange_basis_eval.sv
// Equispaced Lagrange basis evaluator on a simplex, driven by a microcoded sequencer.
// A factor after saturation only updates the sign, and a zero factor ends the item.
// An order above the limit goes straight to the result. Each factor is set by the
// digit divider and the split multiply; one item is in flight at a time.
// Synchronous reset clears the sequencer, divider and output valid; dimension becomes 2.
`default_nettype none

module simplex_lagrange_basis_eval (
  input  logic                       clk,
  input  logic                       rst,
  // Fields: lattice_0..lattice_3 (4 b each), coord_0..coord_2 (32 b each).
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sleb_pkg::IN_W-1:0]  s_tdata,
  // Fields: phi_value (48 b).
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sleb_pkg::OUT_W-1:0] m_tdata,
  // Fields: overflow (1 b).
  output logic [0:0]                 m_tuser,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sleb_pkg::DIM_W-1:0] cfg_data
);
  import sleb_pkg::*;

  logic [DIM_W-1:0] dimension;
  ucw_t             cw;
  dp_stat_t         stat;
  logic             advance;
  logic             out_busy;
  logic             load_out;
  logic [OUT_W-1:0] res_value;
  logic             res_ovf;

  // Dimension register, written by its own channel.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (cfg_valid) begin
      dimension <= cfg_data;
    end
  end

  // Input is taken only in the load step.
  assign s_tready = (cw.op == OP_LOAD);
  assign out_busy = m_tvalid && !m_tready;
  assign load_out = advance && (cw.op == OP_OUT);

  sleb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_valid (s_tvalid),
    .out_busy (out_busy),
    .cw       (cw),
    .advance  (advance)
  );

  sleb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (cw.op),
    .exec      (advance),
    .dim       (dimension),
    .lat_in    (s_tdata[LAT_N*LAT_W-1:0]),
    .crd_in    (s_tdata[IN_W-1:LAT_N*LAT_W]),
    .stat      (stat),
    .res_value (res_value),
    .res_ovf   (res_ovf)
  );

  // Output register decouples the result from the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata    <= res_value;
      m_tuser[0] <= res_ovf;
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the simplex Lagrange basis evaluator.
`timescale 1ns / 100ps

module tb;
  import sleb_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES   = 250;
  localparam int RANDOM_PER_DIM = 100;
  localparam int NUM_DIRECTED   = 24;
  localparam int NUM_PHASES     = 7;

  // One input item; packing order puts lattice_0 in the lowest bits, as on s_tdata.
  typedef struct packed {
    logic signed [CRD_W-1:0] crd2;
    logic signed [CRD_W-1:0] crd1;
    logic signed [CRD_W-1:0] crd0;
    logic [LAT_W-1:0]        lat3;
    logic [LAT_W-1:0]        lat2;
    logic [LAT_W-1:0]        lat1;
    logic [LAT_W-1:0]        lat0;
  } basis_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] phi;
    logic             ovf;
  } basis_result_t;

  // Directed stimulus row; known marks a row whose result is typed in.
  typedef struct packed {
    logic [DIM_W-1:0] dim;
    logic [3:0]       l0, l1, l2, l3;
    logic [31:0]      c0, c1, c2;
    logic             known;
    logic [OUT_W-1:0] phi;
    logic             ovf;
  } basis_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0]       m_tuser;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [DIM_W-1:0] cfg_data;

  basis_result_t    expected_phi_q [$];
  logic [DIM_W-1:0] dim_shadow;
  int               mismatch_count = 0;
  int               s_calm = 0;
  int               m_calm = 0;

  logic [DIM_W-1:0] random_dims [NUM_PHASES] = '{2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1};

  basis_row_t directed_rows [NUM_DIRECTED] = '{
    // Dimension two, the setting after reset.
    '{2'd2, 4'd0, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0, 1'b1, 48'h10000000, 1'b0},
    '{2'd2, 4'd0, 4'd0, 4'd0, 4'd15, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
      1'b1, 48'h10000000, 1'b0},
    '{2'd2, 4'd8, 4'd1, 4'd0, 4'd0, 32'h1, 32'h2, 32'h3, 1'b1, 48'h0, 1'b1},
    '{2'd2, 4'd15, 4'd15, 4'd15, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1'b1, 48'h0, 1'b1},
    '{2'd2, 4'd1, 4'd0, 4'd0, 4'd0, 32'h0, 32'h12345678, 32'h0, 1'b1, 48'h0, 1'b0},
    '{2'd2, 4'd8, 4'd0, 4'd0, 4'd0, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b1, SAT_POS, 1'b1},
    '{2'd2, 4'd7, 4'd1, 4'd0, 4'd0, 32'h80000000, 32'h10000000, 32'h0, 1'b1, SAT_NEG, 1'b1},
    '{2'd2, 4'd2, 4'd2, 4'd2, 4'd0, 32'h04000000, 32'h08000000, 32'h0, 1'b0, 48'h0, 1'b0},
    '{2'd2, 4'd0, 4'd0, 4'd3, 4'd0, 32'h02000000, 32'h03000000, 32'h0, 1'b0, 48'h0, 1'b0},
    '{2'd2, 4'd1, 4'd1, 4'd1, 4'd0, 32'h0AAAAAAA, 32'h05555555, 32'h0, 1'b0, 48'h0, 1'b0},
    '{2'd2, 4'd0, 4'd0, 4'd1, 4'd0, 32'h08000000, 32'h08000000, 32'h0, 1'b1, 48'h0, 1'b0},
    // Saturates on the first coordinate, then a zero factor from w.
    '{2'd2, 4'd7, 4'd0, 4'd1, 4'd0, 32'h7FFFFFFF, 32'h90000001, 32'h0, 1'b1, 48'h0, 1'b0},
    // Dimension three.
    '{2'd3, 4'd0, 4'd0, 4'd0, 4'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
      1'b1, 48'h10000000, 1'b0},
    '{2'd3, 4'd2, 4'd2, 4'd2, 4'd2, 32'h02000000, 32'h02000000, 32'h02000000,
      1'b0, 48'h0, 1'b0},
    '{2'd3, 4'd1, 4'd1, 4'd1, 4'd1, 32'h80000000, 32'h80000000, 32'h80000000,
      1'b0, 48'h0, 1'b0},
    '{2'd3, 4'd0, 4'd0, 4'd0, 4'd9, 32'h0, 32'h0, 32'h0, 1'b1, 48'h0, 1'b1},
    // Dimension one; the upper lattice entries and coordinates are ignored.
    '{2'd1, 4'd1, 4'd0, 4'd15, 4'd15, 32'h10000000, 32'hFFFFFFFF, 32'h80000000,
      1'b1, 48'h10000000, 1'b0},
    '{2'd1, 4'd0, 4'd1, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0, 1'b1, 48'h10000000, 1'b0},
    '{2'd1, 4'd3, 4'd5, 4'd0, 4'd0, 32'h06000000, 32'h0, 32'h0, 1'b0, 48'h0, 1'b0},
    '{2'd1, 4'd4, 4'd4, 4'd0, 4'd0, 32'h80000000, 32'h0, 32'h0, 1'b0, 48'h0, 1'b0},
    // Point simplex: only lattice_0 counts and w is one.
    '{2'd0, 4'd3, 4'd15, 4'd15, 4'd15, 32'h7FFFFFFF, 32'h80000000, 32'h12345678,
      1'b1, 48'h10000000, 1'b0},
    '{2'd0, 4'd9, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0, 1'b1, 48'h0, 1'b1},
    '{2'd0, 4'd0, 4'd15, 4'd15, 4'd15, 32'h0, 32'h0, 32'h0, 1'b1, 48'h10000000, 1'b0},
    '{2'd0, 4'd8, 4'd0, 4'd0, 4'd0, 32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F,
      1'b0, 48'h0, 1'b0}
  };

  simplex_lagrange_basis_eval u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Basis value of one item: running Q.28 magnitude with a separate sign,
  // each factor rounded half away from zero after division by its k.
  function automatic basis_result_t eval_basis(input basis_item_t it, input logic [DIM_W-1:0] dim);
    basis_result_t res;
    logic [3:0]    lat [4];
    longint        crd [3];
    longint        w, xv, t;
    logic [63:0]   mag, tmag;
    logic [127:0]  prod, quo;
    int            ord, q, p, kk;
    bit            neg, sat, hit_zero;
    lat[0] = it.lat0;
    lat[1] = it.lat1;
    lat[2] = it.lat2;
    lat[3] = it.lat3;
    crd[0] = it.crd0;
    crd[1] = it.crd1;
    crd[2] = it.crd2;
    ord = 0;
    for (q = 0; q <= dim; q++) ord += lat[q];
    if (ord > MAX_ORDER) begin
      res.phi = '0;
      res.ovf = 1'b1;
      return res;
    end
    w = ONE_Q;
    mag = ONE_Q;
    neg = 0;
    sat = 0;
    hit_zero = 0;
    // Coordinates first, then w once all coordinates are subtracted.
    for (q = 0; q <= dim; q++) begin
      if (q < dim) begin
        xv = crd[q];
        w -= crd[q];
      end else begin
        xv = w;
      end
      for (p = 0; p < lat[q]; p++) begin
        t = longint'(ord) * xv - longint'(p) * ONE_Q;
        kk = lat[q] - p;
        if (t == 0) begin
          hit_zero = 1;
        end else begin
          if (t < 0) begin
            neg = !neg;
            tmag = 64'(-t);
          end else begin
            tmag = 64'(t);
          end
          // Once zero or saturated, only the sign is still tracked.
          if (!hit_zero && !sat) begin
            prod = 128'(mag) * 128'(tmag) + (128'(kk) << 27);
            quo = (prod >> FRAC) / 128'(kk);
            if (quo >= (128'd1 << 47)) sat = 1;
            else mag = quo[63:0];
          end
        end
      end
    end
    if (hit_zero) begin
      res.phi = '0;
      res.ovf = 1'b0;
    end else if (sat) begin
      res.phi = neg ? SAT_NEG : SAT_POS;
      res.ovf = 1'b1;
    end else begin
      res.phi = neg ? OUT_W'(-mag) : OUT_W'(mag);
      res.ovf = 1'b0;
    end
    return res;
  endfunction

  // Random item: mostly valid orders with mixed coordinate styles, some raw lattices.
  function automatic basis_item_t random_item(input logic [DIM_W-1:0] dim);
    basis_item_t it;
    logic [3:0]  lat [4];
    logic [31:0] crd [3];
    int          ord, q, j, pick;
    for (q = 0; q < 4; q++) lat[q] = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) != 0) begin
      ord = $urandom_range(0, MAX_ORDER);
      for (q = 0; q <= dim; q++) lat[q] = '0;
      for (j = 0; j < ord; j++) begin
        pick = $urandom_range(0, dim);
        lat[pick] = lat[pick] + 4'd1;
      end
    end
    ord = 0;
    for (q = 0; q <= dim; q++) ord += lat[q];
    for (q = 0; q < 3; q++) begin
      case ($urandom_range(0, 7))
        0, 7: begin
          crd[q] = $urandom;
        end
        1: begin
          // Lattice points, so that factors can come out exactly zero.
          if (ord > 0 && ord <= MAX_ORDER && (ord & (ord - 1)) == 0)
            crd[q] = 32'($urandom_range(0, ord) * (ONE_Q / ord));
          else
            crd[q] = $urandom_range(0, 1) ? 32'(ONE_Q) : 32'h0;
        end
        5: begin
          crd[q] = 32'($urandom_range(0, 4 * ONE_Q)) - 32'(2 * ONE_Q);
        end
        6: begin
          case ($urandom_range(0, 3))
            0: crd[q] = 32'h7FFFFFFF;
            1: crd[q] = 32'h80000000;
            2: crd[q] = 32'h0;
            default: crd[q] = 32'hFFFFFFFF;
          endcase
        end
        default: begin
          crd[q] = 32'($urandom_range(0, ONE_Q));
        end
      endcase
    end
    it.lat0 = lat[0];
    it.lat1 = lat[1];
    it.lat2 = lat[2];
    it.lat3 = lat[3];
    it.crd0 = crd[0];
    it.crd1 = crd[1];
    it.crd2 = crd[2];
    return it;
  endfunction

  // Idle cycles before the next transfer, with occasional runs of no idling.
  function automatic int idle_cycles(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 13);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("tb: %s", msg);
  endtask

  // Sends one item; entered and left at a falling edge.
  task automatic send_item(input basis_item_t it, input bit use_typed,
                           input basis_result_t typed_res);
    int gap;
    gap = idle_cycles(s_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      // Sometimes hold off until the block is ready, so the gap meets an idle block.
      if ($urandom_range(0, 1)) begin
        @(posedge clk);
        while (!s_tready) @(posedge clk);
      end
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= it;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_phi_q.push_back(use_typed ? typed_res : eval_basis(it, dim_shadow));
    @(negedge clk);
  endtask

  // Writes the dimension once every expected result has come back.
  task automatic set_dimension(input logic [DIM_W-1:0] dim);
    s_tvalid <= 1'b0;
    while (expected_phi_q.size() != 0) @(negedge clk);
    cfg_data  <= dim;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dim_shadow = dim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus: reset, directed table, then random phases over several dimensions.
  initial begin
    basis_item_t   it;
    basis_result_t typed_res;
    int            i, n;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    dim_shadow = DIM_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].dim != dim_shadow) set_dimension(directed_rows[i].dim);
      it.lat0 = directed_rows[i].l0;
      it.lat1 = directed_rows[i].l1;
      it.lat2 = directed_rows[i].l2;
      it.lat3 = directed_rows[i].l3;
      it.crd0 = directed_rows[i].c0;
      it.crd1 = directed_rows[i].c1;
      it.crd2 = directed_rows[i].c2;
      typed_res.phi = directed_rows[i].phi;
      typed_res.ovf = directed_rows[i].ovf;
      send_item(it, directed_rows[i].known, typed_res);
    end

    typed_res = '0;
    for (i = 0; i < NUM_PHASES; i++) begin
      if (random_dims[i] != dim_shadow) set_dimension(random_dims[i]);
      for (n = 0; n < RANDOM_PER_DIM; n++) send_item(random_item(dim_shadow), 1'b0, typed_res);
    end

    // Let the last results drain, then watch a while for stray transfers.
    s_tvalid <= 1'b0;
    while (expected_phi_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Result side: random stalls, then each transfer is checked against the oldest expectation.
  initial begin
    basis_result_t exp_res;
    int            gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = idle_cycles(m_calm);
      if (gap > 0) begin
        m_tready <= 1'b0;
        // Sometimes stall only after a result is already waiting.
        if ($urandom_range(0, 1)) begin
          @(posedge clk);
          while (!m_tvalid) @(posedge clk);
          @(negedge clk);
        end
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (expected_phi_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected at %0t: phi_value %h overflow %b",
                                $time, m_tdata, m_tuser[0]));
      end else begin
        exp_res = expected_phi_q.pop_front();
        if (m_tdata !== exp_res.phi || m_tuser[0] !== exp_res.ovf)
          flag_mismatch($sformatf("mismatch at %0t: phi_value exp %h got %h, overflow exp %b got %b",
                                  $time, exp_res.phi, m_tdata, exp_res.ovf, m_tuser[0]));
      end
      @(negedge clk);
    end
  end

  // Watchdog on the total run length.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

endmodule

### files.f
rtl/core/sleb_pkg.sv
rtl/core/sleb_div.sv
rtl/core/sleb_seq.sv
rtl/core/sleb_dp.sv
rtl/core/simplex_lagrange_basis_eval.sv
tb/tb.sv
